FILE: sv/isort_pkg.sv
package isort_pkg;

  localparam int VALUE_W       = 31;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_in;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } result_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               valid;
    logic               keep;   // holds its entry through an insert
  } link_t;

  // broadcast to every cell
  typedef struct packed {
    logic               ins;    // insert value this cycle
    logic               shl;    // shift chain toward cell 0
    logic [VALUE_W-1:0] value;
  } ctrl_t;

endpackage

FILE: sv/isort_cell.sv
module isort_cell
  import isort_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctrl_t ctrl,
  input  link_t left,   // toward cell 0
  input  link_t right,  // away from cell 0
  output link_t self
);

  logic [VALUE_W-1:0] value;
  logic               valid;
  logic [VALUE_W-1:0] value_next;
  logic               valid_next;

  // sorted chain: keep bits form a prefix, first non-keep cell takes the new value
  assign self.value = value;
  assign self.valid = valid;
  assign self.keep  = valid && (value <= ctrl.value);

  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctrl.shl) begin
      value_next = right.value;
      valid_next = right.valid;
    end else if (ctrl.ins && !self.keep) begin
      if (left.keep) begin
        value_next = ctrl.value;
        valid_next = 1'b1;
      end else begin
        value_next = left.value;
        valid_next = left.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

FILE: sv/insertion_sorter_core.sv
// Streaming insertion sorter. Send a run of 31-bit unsigned values on the
// item channel, one per request, with last_in set on the final one; each
// value is dropped into place in a chain of MAX_ITEMS cells, behind any
// equal values already held. After the final request the item channel
// stalls and the run comes out on the result channel in ascending order,
// one per cycle while result_stall is low, last_out on the final result.
// The drain length is the number of held values; cell 0 feeds the output
// and the chain shifts down on each accepted result. Values past
// MAX_ITEMS are dropped and overflow is set on every result of that run.
// A new run is taken the cycle after the final result is accepted.
module insertion_sorter_core
  import isort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic [0:0] S_FILL  = 1'b0;
  localparam logic [0:0] S_DRAIN = 1'b1;

  logic [0:0]       state;
  logic [CNT_W-1:0] count;
  logic             dropped;

  logic  item_take;
  logic  result_take;
  logic  full;
  ctrl_t ctrl;
  link_t links [MAX_ITEMS];
  link_t edge_left;
  link_t edge_right;

  assign item_stall   = (state == S_DRAIN);
  assign item_take    = item_valid && !item_stall;
  assign result_valid = (state == S_DRAIN);
  assign result_take  = result_valid && !result_stall;
  assign full         = (count == CNT_W'(MAX_ITEMS));

  assign ctrl.ins   = item_take && !full;
  assign ctrl.shl   = result_take;
  assign ctrl.value = item.value;

  // ends of the chain: cell 0 always inserts when nothing ahead keeps,
  // the last cell pulls in an empty slot on a shift
  assign edge_left  = '{value: '0, valid: 1'b0, keep: 1'b1};
  assign edge_right = '{value: '0, valid: 1'b0, keep: 1'b0};

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isort_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  ((i == 0) ? edge_left : links[(i == 0) ? 0 : i-1]),
      .right ((i == MAX_ITEMS-1) ? edge_right : links[(i == MAX_ITEMS-1) ? i : i+1]),
      .self  (links[i])
    );
  end

  assign result.sorted_value = links[0].value;
  assign result.last_out     = (count == CNT_W'(1));
  assign result.overflow     = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        S_FILL: begin
          if (item_take) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (item.last_in) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (result_take) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state   <= S_FILL;
              dropped <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_FILL;
        end
      endcase
    end
  end

endmodule

FILE: test/tb_insertion_sorter_core.sv
module tb_insertion_sorter_core;
  import isort_pkg::*;

  localparam int CAP        = MAX_ITEMS_DEF;
  localparam int IDLE_LIMIT = 5000;   // cycles with no request and no result taken
  localparam int DRAIN_WAIT = 20;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  insertion_sorter_core #(.MAX_ITEMS(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sorted copy of the current run, and results still owed by the block
  logic [VALUE_W-1:0] run_sorted[$];
  logic               run_dropped = 1'b0;
  result_t            owed_results[$];

  int  fail_count     = 0;
  int  runs_sent      = 0;
  int  values_sent    = 0;
  int  results_seen   = 0;
  int  overflow_runs  = 0;
  int  idle_cycles    = 0;
  int  stall_left     = 0;
  bit  gaps_off       = 1'b0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gaps_off || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // mix of small values (lots of ties), full range and values near the top
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 2))
      0: v = VALUE_W'($urandom_range(0, 7));
      1: v = VALUE_W'($urandom());
      default: v = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 7));
    endcase
    return v;
  endfunction

  // Predictor: insert behind equal values; drop once CAP values are held.
  // The final request flushes the run in order and clears the run state.
  task automatic absorb_value(input logic [VALUE_W-1:0] v, input logic fin);
    int      pos;
    result_t r;
    if (run_sorted.size() >= CAP) begin
      run_dropped = 1'b1;
    end else begin
      pos = run_sorted.size();
      while (pos > 0 && run_sorted[pos-1] > v) pos--;
      run_sorted.insert(pos, v);
    end
    if (fin) begin
      foreach (run_sorted[k]) begin
        r.sorted_value = run_sorted[k];
        r.last_out     = (k == run_sorted.size() - 1);
        r.overflow     = run_dropped;
        owed_results.insert(owed_results.size(), r);
      end
      if (run_dropped) overflow_runs++;
      runs_sent++;
      run_sorted.delete();
      run_dropped = 1'b0;
    end
  endtask

  // One request on the item channel. Valid stays up between back-to-back
  // requests; it is only lowered when a gap follows.
  task automatic push_request(input logic [VALUE_W-1:0] v, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    item.value    <= v;
    item.last_in  <= fin;
    do @(posedge clk); while (item_stall);
    values_sent++;
    absorb_value(v, fin);
  endtask

  task automatic send_run(input int len);
    for (int k = 0; k < len; k++) push_request(pick_value(), k == len - 1);
  endtask

  // Result side: random stall stretches, sharing the gap shape
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      result_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Result checker: every taken result against the oldest owed one
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result value=%0h last=%0b ovf=%0b", $time,
                 result.sorted_value, result.last_out, result.overflow);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (result.sorted_value !== want.sorted_value) begin
          $display("%0t: sorted_value expected %0h got %0h", $time,
                   want.sorted_value, result.sorted_value);
          fail_count++;
        end
        if (result.last_out !== want.last_out) begin
          $display("%0t: last_out expected %0b got %0b", $time,
                   want.last_out, result.last_out);
          fail_count++;
        end
        if (result.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b got %0b", $time,
                   want.overflow, result.overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: nothing moved on either channel for too long
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, owed_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Runs of one: smallest and largest value
  task automatic test_lone_values();
    push_request('0, 1'b1);
    push_request({VALUE_W{1'b1}}, 1'b1);
  endtask

  // Ties must keep arrival order; reverse and already sorted input
  task automatic test_duplicate_order();
    push_request(31'd5, 1'b0);
    push_request(31'd3, 1'b0);
    push_request(31'd5, 1'b0);
    push_request(31'd0, 1'b0);
    push_request({VALUE_W{1'b1}}, 1'b0);
    push_request(31'd3, 1'b1);
    for (int k = 4; k >= 0; k--) push_request(VALUE_W'(k), k == 0);
    for (int k = 0; k < 4; k++) push_request(VALUE_W'(k * 100), k == 3);
  endtask

  // Alternating bit patterns so every value bit toggles both ways
  task automatic test_bit_patterns();
    push_request(31'h2AAA_AAAA, 1'b0);
    push_request(31'h5555_5555, 1'b0);
    push_request(31'h4000_0000, 1'b0);
    push_request(31'h0000_0001, 1'b1);
  endtask

  // Short runs of random length, half of them with no idling at all
  task automatic test_random_runs();
    for (int r = 0; r < 8; r++) begin
      gaps_off = (r >= 4);
      send_run($urandom_range(1, 8));
    end
    gaps_off = 1'b0;
  endtask

  // Past capacity, back to back: the store fills, then the extra values,
  // the final one included, are dropped
  task automatic test_overflow_runs();
    gaps_off = 1'b1;
    send_run(CAP + 2);
    gaps_off = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lone_values();
    test_duplicate_order();
    test_bit_patterns();
    test_random_runs();
    test_overflow_runs();

    item_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d values in %0d runs (%0d past capacity); checked %0d sorted results.",
             values_sent, runs_sent, overflow_runs, results_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
